### src/skgt_pkg.sv
package skgt_pkg;

    // Field widths fixed by the item format
    localparam int KEY_W    = 32;
    localparam int SLOT_W   = 9;
    localparam int GLYPH_W  = 16;
    localparam int STATUS_W = 2;

    // Sentinel keys at both ends of the table
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // Item modes
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = 2'd2;

    // Request beat
    typedef struct packed {
        logic                     mode;
        logic signed [KEY_W-1:0]  key;
        logic [SLOT_W-1:0]        slot;
        logic [GLYPH_W-1:0]       glyph;
    } req_t;

    // Response beat
    typedef struct packed {
        logic                     hit;
        logic [GLYPH_W-1:0]       glyph_out;
        logic [SLOT_W-1:0]        insert_slot;
        logic [STATUS_W-1:0]      status;
    } rsp_t;

    // Datapath operations issued by the controller, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT_MIN,
        OP_INIT_MAX,
        OP_CAPTURE,
        OP_PROBE_RD,
        OP_PROBE_UPD,
        OP_FINAL_RD,
        OP_FINAL_EVAL,
        OP_LOW_RD,
        OP_HIGH_RD,
        OP_SET_FULL,
        OP_SET_BAD,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_INS_WR,
        OP_LOAD_OUT
    } dp_op_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic full;        // entry count at capacity
        logic slot_ok;     // 1 <= slot <= count-1
        logic lo_eq_hi;    // search window closed
        logic order_ok;    // key fits strictly between its neighbors
        logic shift_done;  // shift pointer reached the slot
    } dp_sts_t;

endpackage

### src/sorted_key_glyph_table.sv
// Channel   Signals                        Beat
// --------  -----------------------------  --------------------------------
// req       req_valid, req_stall, req      mode, key, slot, glyph
// rsp       rsp_valid, rsp_stall, rsp      hit, glyph_out, insert_slot, status
//
// One item at a time. Lookup: each binary-search step reads the midpoint over the single
// read port of the table memory, then narrows the window.
// Insert: a full table or out-of-range slot is rejected before the neighbors are read, bad
// ordering after; otherwise entries move up one place at a time, top first.
// After reset, S_INIT_MIN and S_INIT_MAX write the sentinel entries before req is taken.
// The finished beat sits in an output register; rsp_stall holds it there and keeps the next result waiting.
module sorted_key_glyph_table #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  skgt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output skgt_pkg::rsp_t rsp
);

    skgt_pkg::dp_op_t  op;
    skgt_pkg::dp_sts_t sts;

    skgt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req.mode),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .op        (op)
    );

    skgt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .req   (req),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

### src/skgt_dp.sv
module skgt_dp #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  skgt_pkg::dp_op_t  op,
    input  skgt_pkg::req_t    req,
    output skgt_pkg::dp_sts_t sts,
    output skgt_pkg::rsp_t    rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > skgt_pkg::SLOT_W) ? CNT_W : skgt_pkg::SLOT_W;

    // Table storage
    logic signed [skgt_pkg::KEY_W-1:0] key_mem   [TABLE_ENTRIES];
    logic [skgt_pkg::GLYPH_W-1:0]      glyph_mem [TABLE_ENTRIES];

    // Captured beat and search state
    logic signed [skgt_pkg::KEY_W-1:0] key_reg;
    logic [skgt_pkg::SLOT_W-1:0]       slot_reg;
    logic [skgt_pkg::GLYPH_W-1:0]      glyph_reg;
    logic [IDX_W-1:0]                  lo_reg, lo_next;
    logic [IDX_W-1:0]                  hi_reg, hi_next;
    logic [IDX_W-1:0]                  ptr_reg, ptr_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic                              low_ok_reg;
    skgt_pkg::rsp_t                    res_reg, res_next;
    skgt_pkg::rsp_t                    rsp_reg;

    // Memory read data
    logic signed [skgt_pkg::KEY_W-1:0] rd_key_reg;
    logic [skgt_pkg::GLYPH_W-1:0]      rd_glyph_reg;

    // Memory port controls
    logic                              we;
    logic [IDX_W-1:0]                  waddr;
    logic signed [skgt_pkg::KEY_W-1:0] wkey;
    logic [skgt_pkg::GLYPH_W-1:0]      wglyph;
    logic [IDX_W-1:0]                  raddr;

    logic [IDX_W:0]                    mid_sum;
    logic [IDX_W-1:0]                  mid;
    logic [IDX_W-1:0]                  slot_idx;
    logic [CMP_W-1:0]                  slot_ext;
    logic [CMP_W-1:0]                  count_ext;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[IDX_W:1];
    assign slot_idx  = IDX_W'(slot_reg);
    assign slot_ext  = CMP_W'(slot_reg);
    assign count_ext = CMP_W'(count_reg);

    // Status toward the controller
    assign sts.full       = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign sts.slot_ok    = (slot_ext != '0) && (slot_ext < count_ext);
    assign sts.lo_eq_hi   = (lo_reg == hi_reg);
    assign sts.order_ok   = low_ok_reg && (key_reg < rd_key_reg);
    assign sts.shift_done = (ptr_reg == slot_idx);

    assign rsp = rsp_reg;

    // Memory port decode
    always_comb
    begin
        we     = 1'b0;
        waddr  = '0;
        wkey   = rd_key_reg;
        wglyph = rd_glyph_reg;
        raddr  = '0;
        unique case (op)
            skgt_pkg::OP_INIT_MIN:
            begin
                we     = 1'b1;
                waddr  = '0;
                wkey   = skgt_pkg::KEY_MIN;
                wglyph = '0;
            end
            skgt_pkg::OP_INIT_MAX:
            begin
                we     = 1'b1;
                waddr  = IDX_W'(1);
                wkey   = skgt_pkg::KEY_MAX;
                wglyph = '0;
            end
            skgt_pkg::OP_PROBE_RD: raddr = mid;
            skgt_pkg::OP_FINAL_RD: raddr = lo_reg;
            skgt_pkg::OP_LOW_RD:   raddr = slot_idx - IDX_W'(1);
            skgt_pkg::OP_HIGH_RD:  raddr = slot_idx;
            skgt_pkg::OP_SHIFT_RD: raddr = ptr_reg - IDX_W'(1);
            skgt_pkg::OP_SHIFT_WR:
            begin
                we    = 1'b1;
                waddr = ptr_reg;
            end
            skgt_pkg::OP_INS_WR:
            begin
                we     = 1'b1;
                waddr  = slot_idx;
                wkey   = key_reg;
                wglyph = glyph_reg;
            end
            default: ;
        endcase
    end

    // Table memory, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr]   <= wkey;
            glyph_mem[waddr] <= wglyph;
        end
        rd_key_reg   <= key_mem[raddr];
        rd_glyph_reg <= glyph_mem[raddr];
    end

    // Search window, shift pointer, entry count and pending result
    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        res_next   = res_reg;
        unique case (op)
            skgt_pkg::OP_CAPTURE:
            begin
                lo_next  = '0;
                hi_next  = IDX_W'(count_reg - CNT_W'(1));
                ptr_next = IDX_W'(count_reg);
                res_next = '0;
            end
            skgt_pkg::OP_PROBE_UPD:
            begin
                if (rd_key_reg < key_reg)
                    lo_next = mid + IDX_W'(1);
                else
                    hi_next = mid;
            end
            skgt_pkg::OP_FINAL_EVAL:
            begin
                if (rd_key_reg == key_reg)
                begin
                    res_next.hit       = 1'b1;
                    res_next.glyph_out = rd_glyph_reg;
                end
                else
                    res_next.insert_slot = skgt_pkg::SLOT_W'(lo_reg);
            end
            skgt_pkg::OP_SET_FULL: res_next.status = skgt_pkg::STATUS_FULL;
            skgt_pkg::OP_SET_BAD:  res_next.status = skgt_pkg::STATUS_BAD_SLOT;
            skgt_pkg::OP_SHIFT_WR: ptr_next = ptr_reg - IDX_W'(1);
            skgt_pkg::OP_INS_WR:   count_next = count_reg + CNT_W'(1);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg    <= '0;
            hi_reg    <= '0;
            ptr_reg   <= '0;
            count_reg <= CNT_W'(2);
        end
        else
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (op == skgt_pkg::OP_CAPTURE)
        begin
            key_reg   <= req.key;
            slot_reg  <= req.slot;
            glyph_reg <= req.glyph;
        end
        // lower neighbor arrives while the upper one is being read
        if (op == skgt_pkg::OP_HIGH_RD)
            low_ok_reg <= (rd_key_reg < key_reg);
        if (op == skgt_pkg::OP_LOAD_OUT)
            rsp_reg <= res_reg;
    end

endmodule

### src/skgt_ctrl.sv
module skgt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_mode,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  skgt_pkg::dp_sts_t sts,
    output skgt_pkg::dp_op_t  op
);

    typedef enum logic [11:0] {
        S_INIT_MIN = 12'b0000_0000_0001,
        S_INIT_MAX = 12'b0000_0000_0010,
        S_IDLE     = 12'b0000_0000_0100,
        S_SEARCH   = 12'b0000_0000_1000,
        S_COMPARE  = 12'b0000_0001_0000,
        S_FINAL    = 12'b0000_0010_0000,
        S_CHK_SLOT = 12'b0000_0100_0000,
        S_HIGH     = 12'b0000_1000_0000,
        S_ORDER    = 12'b0001_0000_0000,
        S_SHIFT    = 12'b0010_0000_0000,
        S_MOVE     = 12'b0100_0000_0000,
        S_RESP     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op         = skgt_pkg::OP_NONE;
        unique case (state_reg)
            S_INIT_MIN:
            begin
                op         = skgt_pkg::OP_INIT_MIN;
                state_next = S_INIT_MAX;
            end
            S_INIT_MAX:
            begin
                op         = skgt_pkg::OP_INIT_MAX;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op         = skgt_pkg::OP_CAPTURE;
                    state_next = (req_mode == skgt_pkg::MODE_INSERT) ? S_CHK_SLOT : S_SEARCH;
                end
            end
            // binary search: read the midpoint, then narrow the window
            S_SEARCH:
            begin
                if (sts.lo_eq_hi)
                begin
                    op         = skgt_pkg::OP_FINAL_RD;
                    state_next = S_FINAL;
                end
                else
                begin
                    op         = skgt_pkg::OP_PROBE_RD;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                op         = skgt_pkg::OP_PROBE_UPD;
                state_next = S_SEARCH;
            end
            S_FINAL:
            begin
                op         = skgt_pkg::OP_FINAL_EVAL;
                state_next = S_RESP;
            end
            // insert checks: capacity, slot range, neighbor ordering
            S_CHK_SLOT:
            begin
                if (sts.full)
                begin
                    op         = skgt_pkg::OP_SET_FULL;
                    state_next = S_RESP;
                end
                else if (!sts.slot_ok)
                begin
                    op         = skgt_pkg::OP_SET_BAD;
                    state_next = S_RESP;
                end
                else
                begin
                    op         = skgt_pkg::OP_LOW_RD;
                    state_next = S_HIGH;
                end
            end
            S_HIGH:
            begin
                op         = skgt_pkg::OP_HIGH_RD;
                state_next = S_ORDER;
            end
            S_ORDER:
            begin
                if (sts.order_ok)
                    state_next = S_SHIFT;
                else
                begin
                    op         = skgt_pkg::OP_SET_BAD;
                    state_next = S_RESP;
                end
            end
            // move entries up one place, top first
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    op         = skgt_pkg::OP_INS_WR;
                    state_next = S_RESP;
                end
                else
                begin
                    op         = skgt_pkg::OP_SHIFT_RD;
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                op         = skgt_pkg::OP_SHIFT_WR;
                state_next = S_SHIFT;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    op         = skgt_pkg::OP_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output beat valid
    always_comb
    begin
        if (op == skgt_pkg::OP_LOAD_OUT)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT_MIN;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_ENTRIES = 256;
    localparam int BEAT_TARGET   = 950;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int MAX_WAIT      = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    skgt_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    skgt_pkg::rsp_t rsp;

    // Shadow copy of the table, updated as each request beat is taken
    logic signed [skgt_pkg::KEY_W-1:0] tbl_key [TABLE_ENTRIES];
    logic [skgt_pkg::GLYPH_W-1:0]      tbl_glyph [TABLE_ENTRIES];
    int                                tbl_count;

    skgt_pkg::rsp_t pending_answers[$];
    int   mismatch_count = 0;
    int   beats_sent = 0;
    int   cycles = 0;

    // Idle controls for both channels
    logic src_idle = 1'b0;
    logic sink_idle = 1'b0;
    int   sink_wait = 0;
    int   hold_left = 0;

    sorted_key_glyph_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sorted_key_glyph_table regression: fail");
            $finish;
        end
    end

    // Index of the first entry not below key (signed order)
    function automatic int first_not_below(logic signed [skgt_pkg::KEY_W-1:0] key);
        int idx;
        idx = 0;
        while (idx < tbl_count && tbl_key[idx] < key)
            idx++;
        return idx;
    endfunction

    // Expected response for one request; applies accepted inserts to the shadow
    function automatic skgt_pkg::rsp_t table_answer(skgt_pkg::req_t item);
        skgt_pkg::rsp_t ans;
        int   idx;
        int   pos;
        int   s;
        ans = '0;
        s = int'(item.slot);
        if (item.mode == skgt_pkg::MODE_LOOKUP)
        begin
            idx = first_not_below($signed(item.key));
            if (idx < tbl_count && tbl_key[idx] == $signed(item.key))
            begin
                ans.hit = 1'b1;
                ans.glyph_out = tbl_glyph[idx];
            end
            else
                ans.insert_slot = idx[skgt_pkg::SLOT_W-1:0];
        end
        else if (tbl_count >= TABLE_ENTRIES)
            ans.status = skgt_pkg::STATUS_FULL;
        else if (s < 1 || s >= tbl_count || !(tbl_key[s-1] < $signed(item.key))
                 || !($signed(item.key) < tbl_key[s]))
            ans.status = skgt_pkg::STATUS_BAD_SLOT;
        else
        begin
            for (pos = tbl_count; pos > s; pos--)
            begin
                tbl_key[pos] = tbl_key[pos-1];
                tbl_glyph[pos] = tbl_glyph[pos-1];
            end
            tbl_key[s] = $signed(item.key);
            tbl_glyph[s] = item.glyph;
            tbl_count++;
        end
        return ans;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Response side: compare each beat, then draw the next stall stretch
    always @(posedge clk)
    begin : rsp_check
        skgt_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("response beat with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                check_field("hit", int'(want.hit), int'(rsp.hit));
                check_field("glyph_out", int'(want.glyph_out), int'(rsp.glyph_out));
                check_field("insert_slot", int'(want.insert_slot),
                            int'(rsp.insert_slot));
                check_field("status", int'(want.status), int'(rsp.status));
            end
            sink_wait = sink_idle ? $urandom_range(0, MAX_WAIT) : 0;
        end
    end

    // Stall drive; long hold-offs are counted here
    always @(negedge clk)
    begin
        rsp_stall <= (hold_left > 0) || (sink_wait > 0);
        if (hold_left > 0)
            hold_left--;
        if (sink_wait > 0)
            sink_wait--;
    end

    function automatic skgt_pkg::req_t make_req(logic mode,
                                                logic signed [skgt_pkg::KEY_W-1:0] key,
                                                int slot, int glyph);
        skgt_pkg::req_t r;
        r.mode = mode;
        r.key = key;
        r.slot = skgt_pkg::SLOT_W'(slot);
        r.glyph = skgt_pkg::GLYPH_W'(glyph);
        return r;
    endfunction

    // Offer one beat, wait for it to be taken, record its expected response
    task automatic send_item(skgt_pkg::req_t item);
        int gap;
        skgt_pkg::rsp_t ans;
        gap = src_idle ? $urandom_range(0, MAX_WAIT) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!req_stall)
                break;
        end
        ans = table_answer(item);
        pending_answers = {pending_answers, ans};
        beats_sent++;
    endtask

    // Sender goes quiet until every response is back
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [skgt_pkg::KEY_W-1:0] pick_key();
        logic signed [skgt_pkg::KEY_W-1:0] key;
        int i;
        i = $urandom_range(0, tbl_count - 1);
        case ($urandom_range(0, 9))
            0, 1: key = tbl_key[i];
            2: key = $urandom_range(0, 64) - 32;
            3: key = skgt_pkg::KEY_MIN + $urandom_range(0, 3);
            4: key = skgt_pkg::KEY_MAX - $urandom_range(0, 3);
            5: key = $urandom_range(0, 1) ? tbl_key[i] + 32'sd1 : tbl_key[i] - 32'sd1;
            default: key = $urandom();
        endcase
        return key;
    endfunction

    task automatic send_lookup(logic signed [skgt_pkg::KEY_W-1:0] key);
        send_item(make_req(skgt_pkg::MODE_LOOKUP, key, $urandom_range(0, 256),
                           $urandom_range(0, 'hFFFF)));
    endtask

    task automatic send_insert(logic signed [skgt_pkg::KEY_W-1:0] key, int slot);
        send_item(make_req(skgt_pkg::MODE_INSERT, key, slot, $urandom_range(0, 'hFFFF)));
    endtask

    // Lookup miss followed by an insert at the slot it returned
    task automatic insert_well_formed();
        logic signed [skgt_pkg::KEY_W-1:0] k;
        int idx;
        int tries;
        tries = 0;
        do
        begin
            k = (tries < 4) ? pick_key() : $signed($urandom());
            idx = first_not_below(k);
            tries++;
        end
        while (idx < tbl_count && tbl_key[idx] == k && tries < 40);
        send_lookup(k);
        send_insert(k, first_not_below(k));
    endtask

    // Insert that breaks ordering, range or uniqueness
    task automatic insert_broken();
        logic signed [skgt_pkg::KEY_W-1:0] k;
        int s;
        k = pick_key();
        s = first_not_below(k);
        case ($urandom_range(0, 6))
            0: s = 0;
            1: s = $urandom_range(tbl_count, 256);
            2: s = s + 1;
            3: s = (s > 0) ? s - 1 : 0;
            4:
            begin
                k = tbl_key[$urandom_range(0, tbl_count - 1)];
                s = first_not_below(k) + $urandom_range(0, 1);
            end
            5: k = $urandom_range(0, 1) ? skgt_pkg::KEY_MIN : skgt_pkg::KEY_MAX;
            default: s = $urandom_range(0, 256);
        endcase
        if (s > 256)
            s = 256;
        send_insert(k, s);
    endtask

    task automatic random_step();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            send_lookup(pick_key());
        else if (r < 16)
            insert_well_formed();
        else
            insert_broken();
    endtask

    // New idle pattern for both sides; sometimes none at all
    task automatic reshuffle_idle();
        src_idle = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
    endtask

    // Sentinels, ordering rejects, ignored fields, extremes of key and glyph
    task automatic test_directed();
        send_lookup(skgt_pkg::KEY_MIN);
        send_lookup(skgt_pkg::KEY_MAX);
        send_lookup(32'sd0);
        send_insert(32'sd0, 0);
        send_insert(32'sd0, 2);
        send_insert(32'sd0, 256);
        send_insert(skgt_pkg::KEY_MIN, 1);
        send_insert(skgt_pkg::KEY_MAX, 1);
        send_item(make_req(skgt_pkg::MODE_INSERT, 32'sd0, 1, 'hFFFF));
        send_insert(32'sd0, 1);
        send_lookup(32'sd0);
        send_item(make_req(skgt_pkg::MODE_INSERT, -32'sd1, first_not_below(-32'sd1),
                           'h0000));
        send_item(make_req(skgt_pkg::MODE_INSERT, skgt_pkg::KEY_MIN + 1, 1, 'h8001));
        send_item(make_req(skgt_pkg::MODE_INSERT, skgt_pkg::KEY_MAX - 1,
                           first_not_below(skgt_pkg::KEY_MAX - 1), 'h0001));
        send_insert(32'sd1, first_not_below(32'sd0));
        send_lookup(skgt_pkg::KEY_MIN + 1);
        send_lookup(skgt_pkg::KEY_MAX - 1);
        send_lookup(32'sd2);
        send_lookup(-32'sd2);
        send_lookup(skgt_pkg::KEY_MAX);
        send_item(make_req(skgt_pkg::MODE_LOOKUP, -32'sd1, 'h1FF, 'hFFFF));
        send_item(make_req(skgt_pkg::MODE_LOOKUP, 32'sd0, 'h000, 'h0000));
        drain();
    endtask

    task automatic test_random_mix(int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                reshuffle_idle();
                if ($urandom_range(0, 3) == 0)
                    drain();
            end
            random_step();
        end
        drain();
    endtask

    // Receiver holds off while requests keep coming; input must back up
    task automatic test_backpressure();
        int i;
        src_idle = 1'b0;
        sink_idle = 1'b0;
        @(posedge clk);
        hold_left = 1200;
        for (i = 0; i < 8; i++)
            random_step();
        drain();
    endtask

    // Grow the table to capacity, then hit it with full-table rejects
    task automatic test_fill_table();
        int i;
        i = 0;
        while (tbl_count < TABLE_ENTRIES)
        begin
            if (i % 40 == 0)
                reshuffle_idle();
            if ($urandom_range(0, 4) == 0)
                send_lookup(pick_key());
            else
                insert_well_formed();
            i++;
        end
        insert_well_formed();
        send_insert(pick_key(), 0);
        send_insert(pick_key(), 256);
        send_insert(skgt_pkg::KEY_MAX, 1);
        send_lookup(skgt_pkg::KEY_MAX);
        send_lookup(skgt_pkg::KEY_MAX - 32'sd5);
        send_lookup(skgt_pkg::KEY_MIN + 32'sd5);
        drain();
    endtask

    task automatic test_full_table();
        int i;
        i = 0;
        while (beats_sent < BEAT_TARGET)
        begin
            if (i % 40 == 0)
                reshuffle_idle();
            random_step();
            i++;
        end
        drain();
    endtask

    initial
    begin
        tbl_key[0] = skgt_pkg::KEY_MIN;
        tbl_key[1] = skgt_pkg::KEY_MAX;
        tbl_glyph[0] = '0;
        tbl_glyph[1] = '0;
        tbl_count = 2;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_mix(380);
        test_backpressure();
        test_fill_table();
        test_full_table();

        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("sorted_key_glyph_table regression: pass");
        else
            $display("sorted_key_glyph_table regression: fail");
        $finish;
    end

endmodule

### sim.f
src/skgt_pkg.sv
src/skgt_dp.sv
src/skgt_ctrl.sv
src/sorted_key_glyph_table.sv
tb/tb.sv
